// ===== src/psa_pkg.sv =====
// Shared constants, codes and control/status types of the stream slot allocator.
package psa_pkg;

   localparam int MAX_SLOTS_DEFAULT = 8;
   localparam int SLOT_CAP          = 8;

   localparam int CMD_W   = 2;
   localparam int PRIO_W  = 8;
   localparam int VOICE_W = 32;
   localparam int SLOT_W  = 3;
   localparam int STAT_W  = 3;
   localparam int CNT_W   = 4;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_PLAY   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELALL = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

   localparam logic [STAT_W-1:0] STAT_FREE    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_PREEMPT = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NOSLOT  = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FAIL    = 3'd3;
   localparam logic [STAT_W-1:0] STAT_DONE    = 3'd4;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic rel_step;
      logic emit_play;
      logic emit_end;
      logic emit_rel;
      logic emit_empty;
   } psa_ctl_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             idx_done;
      logic             cur_busy;
      logic             out_free;
      logic             rel_last;
   } psa_sts_type;

endpackage

// ===== src/psa_ctrl.sv =====
// Controller state machine of the stream slot allocator.
module psa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  psa_pkg::psa_sts_type  sts,
   output psa_pkg::psa_ctl_type  ctl
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_PLAY_OUT = 3'd2;
   localparam logic [2:0] ST_END_OUT  = 3'd3;
   localparam logic [2:0] ST_REL      = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      ctl        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctl.load = 1'b1;
               unique case (sts.cmd)
                  psa_pkg::CMD_PLAY:   state_in = ST_SCAN;
                  psa_pkg::CMD_END:    state_in = ST_END_OUT;
                  psa_pkg::CMD_RELALL: state_in = ST_REL;
                  default:             state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            ctl.scan_step = 1'b1;
            // The scan ends at the slot limit or at the first free slot.
            if (sts.idx_done || !sts.cur_busy) begin
               state_in = ST_PLAY_OUT;
            end
         end
         ST_PLAY_OUT: begin
            if (sts.out_free) begin
               ctl.emit_play = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_END_OUT: begin
            if (sts.out_free) begin
               ctl.emit_end = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_REL: begin
            // Reaching the limit here means no slot was busy at all.
            priority if (sts.idx_done) begin
               if (sts.out_free) begin
                  ctl.emit_empty = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else if (sts.cur_busy) begin
               if (sts.out_free) begin
                  ctl.emit_rel = 1'b1;
                  if (sts.rel_last) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               ctl.rel_step = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/psa_datapath.sv =====
// Slot table, scan registers and result register of the stream slot allocator.
module psa_datapath #(
   parameter int MAX_SLOTS = psa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wen,
   input  logic [psa_pkg::CNT_W-1:0]         csr_wdata,
   input  logic [psa_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [psa_pkg::CMD_W-1:0]         req_tuser,
   input  psa_pkg::psa_ctl_type              ctl,
   output psa_pkg::psa_sts_type              sts,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [psa_pkg::STAT_W-1:0]        rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int LIM   = (MAX_SLOTS < psa_pkg::SLOT_CAP) ? MAX_SLOTS : psa_pkg::SLOT_CAP;
   localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;
   localparam int CNT_W = psa_pkg::CNT_W;

   // Slot table.
   logic [CNT_W-1:0]            active_ff, active_in;
   logic [LIM-1:0]              busy_ff, busy_in;
   logic [psa_pkg::PRIO_W-1:0]  prio_ff  [LIM];
   logic [psa_pkg::VOICE_W-1:0] voice_ff [LIM];
   logic                        tbl_we;
   logic [IDX_W-1:0]            tbl_idx;

   // Latched request.
   logic [psa_pkg::PRIO_W-1:0]  rprio_ff;
   logic                        rok_ff;
   logic [psa_pkg::VOICE_W-1:0] rvoice_ff;
   logic [psa_pkg::SLOT_W-1:0]  rended_ff;

   // Scan state.
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic                        free_found_ff, free_found_in;
   logic [IDX_W-1:0]            free_slot_ff, free_slot_in;
   logic                        best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]            best_slot_ff, best_slot_in;
   logic [psa_pkg::PRIO_W-1:0]  best_prio_ff, best_prio_in;

   // Result register.
   logic                        out_valid_ff, out_valid_in;
   logic [psa_pkg::STAT_W-1:0]  out_stat_ff, out_stat_in;
   logic [psa_pkg::SLOT_W-1:0]  out_slot_ff, out_slot_in;
   logic [psa_pkg::VOICE_W-1:0] out_voice_ff, out_voice_in;
   logic                        out_rv_ff, out_rv_in;
   logic [CNT_W-1:0]            out_cnt_ff, out_cnt_in;
   logic                        out_last_ff, out_last_in;

   logic [IDX_W-1:0]            cur_idx;
   logic                        idx_done;
   logic                        cur_busy;
   logic                        more_busy;
   logic                        emit;
   logic [IDX_W-1:0]            voice_rd_idx;
   logic [psa_pkg::VOICE_W-1:0] voice_rd;
   logic [IDX_W-1:0]            play_slot;
   logic                        play_write;
   logic                        ended_hit;
   logic [CNT_W-1:0]            busy_cnt;
   logic [CNT_W-1:0]            cfg_sat;

   assign cur_idx  = idx_ff[IDX_W-1:0];
   assign idx_done = (idx_ff >= active_ff);
   assign cur_busy = !idx_done && busy_ff[cur_idx];
   assign emit     = ctl.emit_play | ctl.emit_end | ctl.emit_rel | ctl.emit_empty;

   // One shared read port on the voice table.
   assign voice_rd_idx = ctl.emit_rel ? cur_idx : best_slot_ff;
   assign voice_rd     = voice_ff[voice_rd_idx];

   assign play_slot  = free_found_ff ? free_slot_ff : best_slot_ff;
   assign play_write = rok_ff && (free_found_ff || best_valid_ff);
   assign ended_hit  = ({1'b0, rended_ff} < active_ff) && busy_ff[rended_ff[IDX_W-1:0]];
   assign cfg_sat    = (csr_wdata > CNT_W'(LIM)) ? CNT_W'(LIM) : csr_wdata;

   always_comb begin
      more_busy = 1'b0;
      for (int j = 0; j < LIM; j++) begin
         if ((CNT_W'(j) > idx_ff) && busy_ff[j]) begin
            more_busy = 1'b1;
         end
      end
   end

   always_comb begin
      busy_cnt = '0;
      for (int j = 0; j < LIM; j++) begin
         busy_cnt = busy_cnt + CNT_W'(busy_in[j]);
      end
   end

   always_comb begin
      active_in     = active_ff;
      busy_in       = busy_ff;
      tbl_we        = 1'b0;
      tbl_idx       = play_slot;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      best_valid_in = best_valid_ff;
      best_slot_in  = best_slot_ff;
      best_prio_in  = best_prio_ff;
      out_stat_in   = out_stat_ff;
      out_slot_in   = out_slot_ff;
      out_voice_in  = out_voice_ff;
      out_rv_in     = out_rv_ff;
      out_last_in   = out_last_ff;
      out_cnt_in    = out_cnt_ff;

      if (ctl.load) begin
         idx_in        = '0;
         free_found_in = 1'b0;
         best_valid_in = 1'b0;
      end

      if (ctl.scan_step && !idx_done) begin
         idx_in = idx_ff + CNT_W'(1);
         if (!busy_ff[cur_idx]) begin
            free_found_in = 1'b1;
            free_slot_in  = cur_idx;
         end else if ((prio_ff[cur_idx] < rprio_ff) &&
                      (!best_valid_ff || (prio_ff[cur_idx] < best_prio_ff))) begin
            best_valid_in = 1'b1;
            best_slot_in  = cur_idx;
            best_prio_in  = prio_ff[cur_idx];
         end
      end

      if (ctl.rel_step) begin
         idx_in = idx_ff + CNT_W'(1);
      end

      if (ctl.emit_play) begin
         out_last_in  = 1'b1;
         out_slot_in  = '0;
         out_voice_in = '0;
         out_rv_in    = 1'b0;
         if (play_write) begin
            tbl_we               = 1'b1;
            busy_in[play_slot]   = 1'b1;
            out_slot_in          = psa_pkg::SLOT_W'(play_slot);
            if (free_found_ff) begin
               out_stat_in = psa_pkg::STAT_FREE;
            end else begin
               out_stat_in  = psa_pkg::STAT_PREEMPT;
               out_voice_in = voice_rd;
               out_rv_in    = 1'b1;
            end
         end else if (!free_found_ff && !best_valid_ff) begin
            out_stat_in = psa_pkg::STAT_NOSLOT;
         end else begin
            out_stat_in = psa_pkg::STAT_FAIL;
         end
      end

      if (ctl.emit_end) begin
         if (ended_hit) begin
            busy_in[rended_ff[IDX_W-1:0]] = 1'b0;
         end
         out_stat_in  = psa_pkg::STAT_DONE;
         out_slot_in  = rended_ff;
         out_voice_in = '0;
         out_rv_in    = 1'b0;
         out_last_in  = 1'b1;
      end

      if (ctl.emit_rel) begin
         busy_in[cur_idx] = 1'b0;
         idx_in           = idx_ff + CNT_W'(1);
         out_stat_in      = psa_pkg::STAT_DONE;
         out_slot_in      = psa_pkg::SLOT_W'(cur_idx);
         out_voice_in     = voice_rd;
         out_rv_in        = 1'b1;
         out_last_in      = !more_busy;
      end

      if (ctl.emit_empty) begin
         out_stat_in  = psa_pkg::STAT_DONE;
         out_slot_in  = '0;
         out_voice_in = '0;
         out_rv_in    = 1'b0;
         out_last_in  = 1'b1;
      end

      // Release-all reports the count after every slot has been freed.
      if (ctl.emit_play || ctl.emit_end) begin
         out_cnt_in = busy_cnt;
      end else if (ctl.emit_rel || ctl.emit_empty) begin
         out_cnt_in = '0;
      end

      if (csr_wen) begin
         active_in = cfg_sat;
         busy_in   = '0;
      end
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         busy_ff       <= '0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         best_valid_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         busy_ff       <= busy_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
         free_found_ff <= free_found_in;
         best_valid_ff <= best_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         prio_ff[tbl_idx]  <= rprio_ff;
         voice_ff[tbl_idx] <= rvoice_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         rprio_ff  <= req_tdata[7:0];
         rok_ff    <= req_tdata[8];
         rvoice_ff <= req_tdata[40:9];
         rended_ff <= req_tdata[43:41];
      end
      free_slot_ff <= free_slot_in;
      best_slot_ff <= best_slot_in;
      best_prio_ff <= best_prio_in;
      out_stat_ff  <= out_stat_in;
      out_slot_ff  <= out_slot_in;
      out_voice_ff <= out_voice_in;
      out_rv_ff    <= out_rv_in;
      out_cnt_ff   <= out_cnt_in;
      out_last_ff  <= out_last_in;
   end

   always_comb begin
      // The controller decodes the command straight from the port while idle.
      sts.cmd      = req_tuser;
      sts.idx_done = idx_done;
      sts.cur_busy = cur_busy;
      sts.out_free = !out_valid_ff || rsp_tready;
      sts.rel_last = !more_busy;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_stat_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {out_cnt_ff, out_rv_ff, out_voice_ff, out_slot_ff};

endmodule

// ===== src/priority_stream_slot_allocator_unit.sv =====
// Top level of the priority stream slot allocator.
//
// Keeps up to eight stream slots, each with a busy mark, a priority and a voice id.
// Commands arrive on the req_ stream (command in req_tuser), results leave on the
// rsp_ stream (status in rsp_tuser, rsp_tlast on the final result of a command).
// csr_wen/csr_wdata set the number of slots in use and free every slot; write it
// only while no command is in flight.
// A play request scans one slot per cycle until the first free slot or the slot
// limit, then writes its result; the scan covers at most N slots, N being the number
// of slots in use, and the controller then returns to idle for the next command.
// A voice-ended command passes through the end-output state to the result register.
// Release-all walks the slots one per cycle, waiting at a busy slot while the output
// register is full, and sends one transaction per busy slot, or one when none is busy.
// The table is updated in the same cycle as the result loads into the output register.
// When the receiver stalls, the result is held in the output register and the
// unit waits before producing the next one. One command is processed at a time.
// Reset empties the table, sets the slot count to zero and drops any pending result.
module priority_stream_slot_allocator_unit #(
   parameter int MAX_SLOTS = psa_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [psa_pkg::CNT_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: priority_req[7:0], play_ok[8], new_voice[40:9], ended_slot[43:41], zero fill
   input  logic [psa_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[1:0]
   input  logic [psa_pkg::CMD_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: slot[2:0], released_voice[34:3], release_valid[35], busy_count[39:36]
   output logic [psa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status[2:0]
   output logic [psa_pkg::STAT_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast
);

   psa_pkg::psa_ctl_type ctl;
   psa_pkg::psa_sts_type sts;

   psa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   psa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Only release-all produces more than one transaction per command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != psa_pkg::STAT_DONE) |-> rsp_tlast)
      else $error("play result without tlast");

   // A released voice comes only with a preemption or a release-all.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |->
         (rsp_tuser == psa_pkg::STAT_PREEMPT) || (rsp_tuser == psa_pkg::STAT_DONE))
      else $error("release flagged on wrong status");

   // The unit never takes a new command while a command is still producing results.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast && !rsp_tready |=> !req_tready)
      else $error("command accepted during release-all");

endmodule
